### design/jsu_pkg.sv
package jsu_pkg;

  localparam int MAX_WIDTH           = 24;
  localparam int LEN_WIDTH           = 24;
  localparam int GROUP_MAX           = 4;
  localparam int GROUP_CNT_WIDTH     = 3;
  localparam int DEFAULT_COUNT_WIDTH = 24;

  localparam logic [MAX_WIDTH-1:0] MAX_RESET = 24'd4096;

  // Input operations.
  localparam logic [1:0] OP_OPEN = 2'd0;
  localparam logic [1:0] OP_TEXT = 2'd1;
  localparam logic [1:0] OP_END  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Error codes.
  localparam logic [3:0] ERR_NONE         = 4'd0;
  localparam logic [3:0] ERR_UNTERMINATED = 4'd1;
  localparam logic [3:0] ERR_CONTROL      = 4'd2;
  localparam logic [3:0] ERR_OPEN_ESC     = 4'd3;
  localparam logic [3:0] ERR_UNKNOWN_ESC  = 4'd4;
  localparam logic [3:0] ERR_TRUNC_HEX    = 4'd5;
  localparam logic [3:0] ERR_NONHEX       = 4'd6;
  localparam logic [3:0] ERR_LONE_HIGH    = 4'd7;
  localparam logic [3:0] ERR_BAD_LOW      = 4'd8;
  localparam logic [3:0] ERR_LONE_LOW     = 4'd9;
  localparam logic [3:0] ERR_TOO_LONG     = 4'd10;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
  } jsu_in_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           out_byte;
    logic [3:0]           error_code;
    logic [LEN_WIDTH-1:0] decoded_length;
    logic                 last;
  } jsu_out_t;

  typedef jsu_out_t [GROUP_MAX-1:0] jsu_group_t;

endpackage

### design/json_string_unescaper_unit.sv
// JSON string body decoder.
// in_valid/in_ready/in_data carry one item a beat: an opening quote, a text
// byte, or end of input. out_valid/out_ready/out_data carry result beats:
// decoded UTF-8 bytes, a completion beat with the decoded length, or an error
// beat; last marks the final result caused by one input item.
// cfg_valid/cfg_ready/cfg_data write the decoded-length limit (always ready);
// write it only while no item is in flight.
// An accepted item waits in the input register until the result buffer is free;
// it is then decoded and its results are loaded into the result buffer.
// Throughput: one item per cycle while each item gives at most one result and
// the receiver takes each beat. An item with several results holds the buffer,
// which sends one beat per cycle; the next item waits in the input register.
// Reset closes any open string, clears the byte count and sets the limit to
// 4096. When the receiver stalls, the result buffer holds its beats, the input
// register fills behind it, and in_ready drops until beats drain.
module json_string_unescaper_unit #(
  parameter int COUNT_WIDTH = jsu_pkg::DEFAULT_COUNT_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  jsu_pkg::jsu_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output jsu_pkg::jsu_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [jsu_pkg::MAX_WIDTH-1:0] cfg_data
);
  import jsu_pkg::*;

  jsu_in_t                    item;
  logic                       item_valid;
  logic [MAX_WIDTH-1:0]       byte_limit;
  logic                       commit;
  logic                       buf_free;
  jsu_group_t                 grp;
  logic [GROUP_CNT_WIDTH-1:0] grp_n;

  assign commit    = item_valid && buf_free;
  assign in_ready  = !item_valid || commit;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      byte_limit <= MAX_RESET;
    end else begin
      if (in_ready) item_valid <= in_valid;
      if (cfg_valid) byte_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item <= in_data;
  end

  jsu_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (commit),
    .item     (item),
    .max_bytes(byte_limit),
    .res      (grp),
    .res_n    (grp_n)
  );

  jsu_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .load     (commit),
    .load_res (grp),
    .load_n   (grp_n),
    .free     (buf_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  a_close_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != KIND_BYTE |-> out_data.last)
    else $error("completion or error beat not marked last");

  a_held_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && !commit |=> item_valid && $stable(item))
    else $error("pending item lost before decode");

endmodule

### design/jsu_core.sv
module jsu_core #(
  parameter int COUNT_WIDTH = jsu_pkg::DEFAULT_COUNT_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 step,
  input  jsu_pkg::jsu_in_t                     item,
  input  logic [jsu_pkg::MAX_WIDTH-1:0]        max_bytes,
  output jsu_pkg::jsu_group_t                  res,
  output logic [jsu_pkg::GROUP_CNT_WIDTH-1:0]  res_n
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    PH_PLAIN   = 3'd0,
    PH_ESC     = 3'd1,
    PH_HEX1    = 3'd2,
    PH_WAIT_BS = 3'd3,
    PH_WAIT_U  = 3'd4,
    PH_HEX2    = 3'd5
  } phase_t;

  localparam int CMP_W = ((COUNT_WIDTH > MAX_WIDTH) ? COUNT_WIDTH : MAX_WIDTH) + 2;
  localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((64'd1 << COUNT_WIDTH) - 64'd1);

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_CTRL  = 8'h20;

  localparam logic [15:0] HIGH_LO = 16'hD800;
  localparam logic [15:0] HIGH_HI = 16'hDBFF;
  localparam logic [15:0] LOW_LO  = 16'hDC00;
  localparam logic [15:0] LOW_HI  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) r = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) r = 5'(c - 8'h61 + 8'd10);
    else if (c >= 8'h41 && c <= 8'h46) r = 5'(c - 8'h41 + 8'd10);
    return r;
  endfunction

  function automatic jsu_out_t make_res(input logic [1:0] kind, input logic [7:0] b,
                                        input logic [3:0] code,
                                        input logic [LEN_WIDTH-1:0] len);
    jsu_out_t r;
    r.kind           = kind;
    r.out_byte       = b;
    r.error_code     = code;
    r.decoded_length = len;
    r.last           = 1'b0;
    return r;
  endfunction

  // String state.
  logic                   active;
  phase_t                 phase;
  logic [1:0]             hex_position;
  logic [15:0]            hex_accum;
  logic [9:0]             high_half;
  logic                   bad_hex_pending;
  logic [COUNT_WIDTH-1:0] decoded_count;

  logic                   active_next;
  phase_t                 phase_next;
  logic [1:0]             hex_position_next;
  logic [15:0]            hex_accum_next;
  logic [9:0]             high_half_next;
  logic                   bad_hex_pending_next;
  logic [COUNT_WIDTH-1:0] decoded_count_next;

  logic        do_fail;
  logic [3:0]  fail_code;
  logic        do_done;
  logic        do_cp;
  logic        raw_byte;
  logic        clear_count;
  logic [20:0] cp;
  logic [4:0]  nib;
  logic [15:0] win;
  logic        win_bad;
  logic [7:0]  seq [GROUP_MAX];
  logic [2:0]  seq_len;
  logic [GROUP_MAX-1:0] room_ok;
  logic [CMP_W-1:0]     cnt_plus [GROUP_MAX];
  logic        stop;
  logic [2:0]  emitted;

  always_comb begin
    nib                  = nibble_of(item.data_byte);
    win                  = nib[4] ? hex_accum : {hex_accum[11:0], nib[3:0]};
    win_bad              = bad_hex_pending | nib[4];
    active_next          = active;
    phase_next           = phase;
    hex_position_next    = hex_position;
    hex_accum_next       = hex_accum;
    high_half_next       = high_half;
    bad_hex_pending_next = bad_hex_pending;
    do_fail              = 1'b0;
    fail_code            = ERR_NONE;
    do_done              = 1'b0;
    do_cp                = 1'b0;
    raw_byte             = 1'b0;
    clear_count          = 1'b0;
    cp                   = '0;

    unique case (item.op)
      OP_OPEN: begin
        active_next          = 1'b1;
        phase_next           = PH_PLAIN;
        hex_position_next    = '0;
        hex_accum_next       = '0;
        high_half_next       = '0;
        bad_hex_pending_next = 1'b0;
        clear_count          = 1'b1;
      end
      OP_TEXT: begin
        if (active) begin
          unique case (phase) inside
            PH_PLAIN: begin
              if (item.data_byte == CH_QUOTE) begin
                do_done = 1'b1;
              end else if (item.data_byte < CH_CTRL) begin
                do_fail = 1'b1; fail_code = ERR_CONTROL;
              end else if (item.data_byte == CH_BSL) begin
                phase_next = PH_ESC;
              end else begin
                // Plain text bytes pass through as they are, without re-encoding.
                do_cp = 1'b1; raw_byte = 1'b1; cp = 21'(item.data_byte);
              end
            end
            PH_ESC: begin
              phase_next = PH_PLAIN;
              do_cp      = 1'b1;
              case (item.data_byte)
                CH_QUOTE: cp = 21'(CH_QUOTE);
                CH_BSL:   cp = 21'(CH_BSL);
                CH_SLASH: cp = 21'(CH_SLASH);
                8'h62:    cp = 21'h08;
                8'h66:    cp = 21'h0C;
                8'h6E:    cp = 21'h0A;
                8'h72:    cp = 21'h0D;
                8'h74:    cp = 21'h09;
                CH_U: begin
                  do_cp                = 1'b0;
                  phase_next           = PH_HEX1;
                  hex_position_next    = '0;
                  hex_accum_next       = '0;
                  bad_hex_pending_next = 1'b0;
                end
                default: begin
                  do_cp = 1'b0; do_fail = 1'b1; fail_code = ERR_UNKNOWN_ESC;
                end
              endcase
            end
            PH_HEX1, PH_HEX2: begin
              hex_accum_next       = win;
              bad_hex_pending_next = win_bad;
              if (hex_position == 2'd3) begin
                // The window is complete: a bad digit is reported only now.
                hex_position_next = '0;
                hex_accum_next    = '0;
                if (win_bad) begin
                  do_fail = 1'b1; fail_code = ERR_NONHEX;
                end else if (phase == PH_HEX1) begin
                  if (win >= HIGH_LO && win <= HIGH_HI) begin
                    high_half_next = win[9:0];
                    phase_next     = PH_WAIT_BS;
                  end else if (win >= LOW_LO && win <= LOW_HI) begin
                    do_fail = 1'b1; fail_code = ERR_LONE_LOW;
                  end else begin
                    phase_next = PH_PLAIN;
                    do_cp      = 1'b1;
                    cp         = 21'(win);
                  end
                end else begin
                  if (win < LOW_LO || win > LOW_HI) begin
                    do_fail = 1'b1; fail_code = ERR_BAD_LOW;
                  end else begin
                    phase_next = PH_PLAIN;
                    do_cp      = 1'b1;
                    cp         = SUPP_BASE + {1'b0, high_half, win[9:0]};
                  end
                end
              end else begin
                hex_position_next = hex_position + 2'd1;
              end
            end
            PH_WAIT_BS: begin
              if (item.data_byte == CH_BSL) phase_next = PH_WAIT_U;
              else begin
                do_fail = 1'b1; fail_code = ERR_LONE_HIGH;
              end
            end
            PH_WAIT_U: begin
              if (item.data_byte == CH_U) begin
                phase_next           = PH_HEX2;
                hex_position_next    = '0;
                hex_accum_next       = '0;
                bad_hex_pending_next = 1'b0;
              end else begin
                do_fail = 1'b1; fail_code = ERR_LONE_HIGH;
              end
            end
            default: begin
              do_fail = 1'b1; fail_code = ERR_UNTERMINATED;
            end
          endcase
        end
      end
      OP_END: begin
        if (active) begin
          do_fail = 1'b1;
          case (phase) inside
            PH_PLAIN:              fail_code = ERR_UNTERMINATED;
            PH_ESC:                fail_code = ERR_OPEN_ESC;
            PH_HEX1, PH_HEX2:      fail_code = ERR_TRUNC_HEX;
            PH_WAIT_BS, PH_WAIT_U: fail_code = ERR_LONE_HIGH;
            default:               fail_code = ERR_UNTERMINATED;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // UTF-8 encoding of the code point.
  always_comb begin
    seq[0] = '0; seq[1] = '0; seq[2] = '0; seq[3] = '0;
    if (raw_byte || cp < 21'h80) begin
      seq[0]  = cp[7:0];
      seq_len = 3'd1;
    end else if (cp < 21'h800) begin
      seq[0]  = {3'b110, cp[10:6]};
      seq[1]  = {2'b10, cp[5:0]};
      seq_len = 3'd2;
    end else if (cp < 21'h10000) begin
      seq[0]  = {4'b1110, cp[15:12]};
      seq[1]  = {2'b10, cp[11:6]};
      seq[2]  = {2'b10, cp[5:0]};
      seq_len = 3'd3;
    end else begin
      seq[0]  = {5'b11110, cp[20:18]};
      seq[1]  = {2'b10, cp[17:12]};
      seq[2]  = {2'b10, cp[11:6]};
      seq[3]  = {2'b10, cp[5:0]};
      seq_len = 3'd4;
    end
  end

  // Result group; a byte that would overrun the limit becomes the too-long error.
  always_comb begin
    res     = '0;
    res_n   = '0;
    stop    = 1'b0;
    emitted = '0;
    for (int i = 0; i < GROUP_MAX; i++) begin
      cnt_plus[i] = CMP_W'(decoded_count) + CMP_W'(i);
      room_ok[i]  = (cnt_plus[i] < CMP_W'(max_bytes)) && (cnt_plus[i] < COUNT_MAX);
    end
    if (do_done) begin
      res[0] = make_res(KIND_DONE, 8'd0, ERR_NONE, LEN_WIDTH'(decoded_count));
      res_n  = 3'd1;
    end else if (do_fail) begin
      res[0] = make_res(KIND_ERR, 8'd0, fail_code, '0);
      res_n  = 3'd1;
    end else if (do_cp) begin
      for (int i = 0; i < GROUP_MAX; i++) begin
        if (!stop && (3'(i) < seq_len)) begin
          if (room_ok[i]) begin
            res[i]  = make_res(KIND_BYTE, seq[i], ERR_NONE, '0);
            emitted = emitted + 3'd1;
          end else begin
            res[i] = make_res(KIND_ERR, 8'd0, ERR_TOO_LONG, '0);
            stop   = 1'b1;
          end
          res_n = res_n + 3'd1;
        end
      end
    end
    decoded_count_next = clear_count ? '0 : decoded_count + COUNT_WIDTH'(emitted);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active          <= 1'b0;
      phase           <= PH_PLAIN;
      hex_position    <= '0;
      hex_accum       <= '0;
      high_half       <= '0;
      bad_hex_pending <= 1'b0;
      decoded_count   <= '0;
    end else if (step) begin
      decoded_count <= decoded_count_next;
      if (do_done || do_fail || stop) begin
        active          <= 1'b0;
        phase           <= PH_PLAIN;
        hex_position    <= '0;
        hex_accum       <= '0;
        high_half       <= '0;
        bad_hex_pending <= 1'b0;
      end else begin
        active          <= active_next;
        phase           <= phase_next;
        hex_position    <= hex_position_next;
        hex_accum       <= hex_accum_next;
        high_half       <= high_half_next;
        bad_hex_pending <= bad_hex_pending_next;
      end
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    step && do_cp && !stop |-> emitted == seq_len)
    else $error("byte count does not match the encoded length");

  a_idle_in_plain: assert property (@(posedge clk) disable iff (rst)
    !active |-> phase == PH_PLAIN && hex_position == 2'd0 && !bad_hex_pending)
    else $error("closed string left escape state behind");

  a_one_result_on_close: assert property (@(posedge clk) disable iff (rst)
    (do_done || do_fail) |-> res_n == 3'd1)
    else $error("completion or fault gave more than one result");

endmodule

### design/jsu_obuf.sv
module jsu_obuf (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  jsu_pkg::jsu_group_t                 load_res,
  input  logic [jsu_pkg::GROUP_CNT_WIDTH-1:0] load_n,
  output logic                                free,
  output logic                                out_valid,
  input  logic                                out_ready,
  output jsu_pkg::jsu_out_t                   out_data
);
  import jsu_pkg::*;

  jsu_group_t                 group;
  logic [GROUP_CNT_WIDTH-1:0] pend;
  logic [1:0]                 rd;

  // A new group may be loaded once the current one has its final beat taken.
  assign free      = (pend == '0) || (pend == 3'd1 && out_ready);
  assign out_valid = (pend != '0);

  always_comb begin
    out_data      = group[rd];
    out_data.last = (pend == 3'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      rd   <= '0;
    end else if (load) begin
      pend <= load_n;
      rd   <= '0;
    end else if (out_valid && out_ready) begin
      pend <= pend - 3'd1;
      rd   <= rd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) group <= load_res;
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("group loaded over undelivered results");

  a_group_size: assert property (@(posedge clk) disable iff (rst)
    load |-> load_n <= 3'd4)
    else $error("result group larger than four");

  a_loaded_shows: assert property (@(posedge clk) disable iff (rst)
    load && load_n != '0 |=> out_valid && rd == 2'd0)
    else $error("loaded group not presented");

endmodule

### tb/tb_json_string_unescaper_unit.sv
module tb_json_string_unescaper_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import jsu_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;

  // Decoder phases inside an open string.
  localparam logic [2:0] PH_PLAIN   = 3'd0;
  localparam logic [2:0] PH_ESC     = 3'd1;
  localparam logic [2:0] PH_HEX1    = 3'd2;
  localparam logic [2:0] PH_WANT_BS = 3'd3;
  localparam logic [2:0] PH_WANT_U  = 3'd4;
  localparam logic [2:0] PH_HEX2    = 3'd5;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [31:0] COUNT_TOP   = 32'((64'd1 << DEFAULT_COUNT_WIDTH) - 1);
  localparam int          STALL_LIMIT = 1000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          PHASE_ITEMS = 42;

  localparam logic [7:0] ESC_LETTERS [8] = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic        typed;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [3:0]  error_code;
    logic [23:0] decoded_length;
  } dir_row_t;

  typedef struct {
    bit       typed;
    jsu_out_t want;
  } row_tag_t;

  // Directed rows: the expected beat is filled in only where it is obvious.
  localparam dir_row_t DIR_ROWS [29] = '{
    '{OP_OPEN,  8'h00, 1'b0, KIND_BYTE, 8'h00, ERR_NONE,         24'd0},
    '{OP_TEXT,  8'h41, 1'b1, KIND_BYTE, 8'h41, ERR_NONE,         24'd0},
    '{OP_TEXT,  8'hFF, 1'b1, KIND_BYTE, 8'hFF, ERR_NONE,         24'd0},
    '{OP_TEXT,  8'h5C, 1'b0, KIND_BYTE, 8'h00, ERR_NONE,         24'd0},
    '{OP_TEXT,  8'h6E, 1'b1, KIND_BYTE, 8'h0A, ERR_NONE,         24'd0},
    '{OP_TEXT,  8'h5C, 1'b0, KIND_BYTE, 8'h00, ERR_NONE,         24'd0},
    '{OP_TEXT,  8'h75, 1'b0, KIND_BYTE, 8'h00, ERR_NONE,         24'd0},
    '{OP_TEXT,  8'h44, 1'b0, KIND_BYTE, 8'h00, ERR_NONE,         24'd0},
    '{OP_TEXT,  8'h38, 1'b0, KIND_BYTE, 8'h00, ERR_NONE,         24'd0},
    '{OP_TEXT,  8'h33, 1'b0, KIND_BYTE, 8'h00, ERR_NONE,         24'd0},
    '{OP_TEXT,  8'h64, 1'b0, KIND_BYTE, 8'h00, ERR_NONE,         24'd0},
    '{OP_TEXT,  8'h5C, 1'b0, KIND_BYTE, 8'h00, ERR_NONE,         24'd0},
    '{OP_TEXT,  8'h75, 1'b0, KIND_BYTE, 8'h00, ERR_NONE,         24'd0},
    '{OP_TEXT,  8'h64, 1'b0, KIND_BYTE, 8'h00, ERR_NONE,         24'd0},
    '{OP_TEXT,  8'h45, 1'b0, KIND_BYTE, 8'h00, ERR_NONE,         24'd0},
    '{OP_TEXT,  8'h30, 1'b0, KIND_BYTE, 8'h00, ERR_NONE,         24'd0},
    '{OP_TEXT,  8'h30, 1'b0, KIND_BYTE, 8'h00, ERR_NONE,         24'd0},
    '{OP_TEXT,  8'h22, 1'b1, KIND_DONE, 8'h00, ERR_NONE,         24'd7},
    '{OP_OPEN,  8'hFF, 1'b0, KIND_BYTE, 8'h00, ERR_NONE,         24'd0},
    '{OP_TEXT,  8'h22, 1'b1, KIND_DONE, 8'h00, ERR_NONE,         24'd0},
    '{OP_OPEN,  8'h00, 1'b0, KIND_BYTE, 8'h00, ERR_NONE,         24'd0},
    '{OP_TEXT,  8'h1F, 1'b1, KIND_ERR,  8'h00, ERR_CONTROL,      24'd0},
    '{OP_TEXT,  8'h00, 1'b0, KIND_BYTE, 8'h00, ERR_NONE,         24'd0},
    '{OP_OPEN,  8'h00, 1'b0, KIND_BYTE, 8'h00, ERR_NONE,         24'd0},
    '{OP_END,   8'h00, 1'b1, KIND_ERR,  8'h00, ERR_UNTERMINATED, 24'd0},
    '{OP_SPARE, 8'hA5, 1'b0, KIND_BYTE, 8'h00, ERR_NONE,         24'd0},
    '{OP_OPEN,  8'h00, 1'b0, KIND_BYTE, 8'h00, ERR_NONE,         24'd0},
    '{OP_TEXT,  8'h5C, 1'b0, KIND_BYTE, 8'h00, ERR_NONE,         24'd0},
    '{OP_END,   8'h00, 1'b1, KIND_ERR,  8'h00, ERR_OPEN_ESC,     24'd0}
  };

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  jsu_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  jsu_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [MAX_WIDTH-1:0] cfg_data = '0;

  // Decoder state as the block should hold it.
  logic [23:0] limit_bytes;
  bit          str_open;
  logic [2:0]  esc_phase;
  logic [1:0]  hex_pos;
  logic [15:0] hex_acc;
  logic [9:0]  high_bits;
  bit          hex_bad;
  logic [31:0] out_count;

  jsu_out_t step_res[$];
  jsu_out_t owed_beats[$];
  row_tag_t row_tag_q[$];
  jsu_in_t  gen_q[$];
  int       fail_count = 0;
  int       idle_cycles = 0;
  bit       in_quiet = 1'b0;
  bit       out_quiet = 1'b0;

  json_string_unescaper_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void add_result(logic [1:0] kind, logic [7:0] b, logic [3:0] err,
                                     logic [31:0] len);
    jsu_out_t r;
    if (step_res.size() >= GROUP_MAX) return;
    r.kind = kind;
    r.out_byte = b;
    r.error_code = err;
    r.decoded_length = len[LEN_WIDTH-1:0];
    r.last = 1'b0;
    step_res = {step_res, r};
  endfunction

  function automatic void close_str();
    str_open = 1'b0;
    esc_phase = PH_PLAIN;
    hex_pos = '0;
    hex_acc = '0;
    high_bits = '0;
    hex_bad = 1'b0;
  endfunction

  function automatic void raise_err(logic [3:0] err);
    add_result(KIND_ERR, 8'h00, err, 32'd0);
    close_str();
  endfunction

  function automatic bit put_byte(logic [7:0] b);
    if (out_count >= {8'd0, limit_bytes} || out_count >= COUNT_TOP) begin
      raise_err(ERR_TOO_LONG);
      return 1'b0;
    end
    add_result(KIND_BYTE, b, ERR_NONE, 32'd0);
    out_count = (out_count + 32'd1) & COUNT_TOP;
    return 1'b1;
  endfunction

  function automatic void put_code_point(logic [20:0] cp);
    logic [7:0] seq [4];
    int n;
    if (cp < 21'h80) begin
      seq[0] = cp[7:0];
      n = 1;
    end else if (cp < 21'h800) begin
      seq[0] = {3'b110, cp[10:6]};
      seq[1] = {2'b10, cp[5:0]};
      n = 2;
    end else if (cp < 21'h10000) begin
      seq[0] = {4'b1110, cp[15:12]};
      seq[1] = {2'b10, cp[11:6]};
      seq[2] = {2'b10, cp[5:0]};
      n = 3;
    end else begin
      seq[0] = {5'b11110, cp[20:18]};
      seq[1] = {2'b10, cp[17:12]};
      seq[2] = {2'b10, cp[11:6]};
      seq[3] = {2'b10, cp[5:0]};
      n = 4;
    end
    for (int i = 0; i < n; i++)
      if (!put_byte(seq[i])) return;
  endfunction

  // Returns 16 for anything that is not a hex digit.
  function automatic logic [4:0] hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    return 5'd16;
  endfunction

  function automatic void finish_window();
    logic [15:0] v;
    bit second;
    v = hex_acc;
    second = (esc_phase == PH_HEX2);
    hex_pos = '0;
    hex_acc = '0;
    if (hex_bad) begin
      raise_err(ERR_NONHEX);
      return;
    end
    if (!second) begin
      if (v >= 16'hD800 && v <= 16'hDBFF) begin
        high_bits = 10'(v - 16'hD800);
        esc_phase = PH_WANT_BS;
      end else if (v >= 16'hDC00 && v <= 16'hDFFF) begin
        raise_err(ERR_LONE_LOW);
      end else begin
        esc_phase = PH_PLAIN;
        put_code_point({5'd0, v});
      end
    end else if (v < 16'hDC00 || v > 16'hDFFF) begin
      raise_err(ERR_BAD_LOW);
    end else begin
      esc_phase = PH_PLAIN;
      put_code_point(21'h10000 + {high_bits, 10'd0} + 21'(v - 16'hDC00));
    end
  endfunction

  function automatic void take_text(logic [7:0] c);
    logic [8:0] simple;
    logic [4:0] nib;
    simple = 9'h100;
    case (esc_phase)
      PH_PLAIN: begin
        if (c == CH_QUOTE) begin
          add_result(KIND_DONE, 8'h00, ERR_NONE, out_count);
          close_str();
        end else if (c < 8'h20) begin
          raise_err(ERR_CONTROL);
        end else if (c == CH_BSLASH) begin
          esc_phase = PH_ESC;
        end else begin
          void'(put_byte(c));
        end
      end
      PH_ESC: begin
        case (c)
          "\"": simple = 9'h022;
          "\\": simple = 9'h05C;
          "/":  simple = 9'h02F;
          "b":  simple = 9'h008;
          "f":  simple = 9'h00C;
          "n":  simple = 9'h00A;
          "r":  simple = 9'h00D;
          "t":  simple = 9'h009;
          "u": begin
            esc_phase = PH_HEX1;
            hex_pos = '0;
            hex_acc = '0;
            hex_bad = 1'b0;
          end
          default: raise_err(ERR_UNKNOWN_ESC);
        endcase
        if (simple != 9'h100) begin
          esc_phase = PH_PLAIN;
          void'(put_byte(simple[7:0]));
        end
      end
      PH_WANT_BS: begin
        if (c == CH_BSLASH) esc_phase = PH_WANT_U;
        else raise_err(ERR_LONE_HIGH);
      end
      PH_WANT_U: begin
        if (c == CH_U) begin
          esc_phase = PH_HEX2;
          hex_pos = '0;
          hex_acc = '0;
          hex_bad = 1'b0;
        end else begin
          raise_err(ERR_LONE_HIGH);
        end
      end
      PH_HEX1, PH_HEX2: begin
        // Every byte in the window counts as a digit; a bad one is only
        // reported once all four have been taken.
        nib = hex_value(c);
        if (nib[4]) hex_bad = 1'b1;
        else hex_acc = {hex_acc[11:0], nib[3:0]};
        if (hex_pos == 2'd3) finish_window();
        else hex_pos = hex_pos + 2'd1;
      end
      default: raise_err(ERR_UNTERMINATED);
    endcase
  endfunction

  function automatic void decode_item(jsu_in_t it);
    logic [3:0] err;
    step_res.delete();
    case (it.op)
      OP_OPEN: begin
        close_str();
        str_open = 1'b1;
        out_count = '0;
      end
      OP_TEXT: if (str_open) take_text(it.data_byte);
      OP_END: begin
        if (str_open) begin
          case (esc_phase)
            PH_ESC:                err = ERR_OPEN_ESC;
            PH_HEX1, PH_HEX2:      err = ERR_TRUNC_HEX;
            PH_WANT_BS, PH_WANT_U: err = ERR_LONE_HIGH;
            default:               err = ERR_UNTERMINATED;
          endcase
          raise_err(err);
        end
      end
      default: ;
    endcase
    if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
  endfunction

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0h got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    row_tag_t tag;
    jsu_out_t want;
    if (rst) begin
      limit_bytes = MAX_RESET;
      close_str();
      out_count = '0;
      owed_beats.delete();
      idle_cycles = 0;
    end else begin
      if (cfg_valid && cfg_ready) limit_bytes = cfg_data;
      if (in_valid && in_ready) begin
        tag = row_tag_q.pop_front();
        decode_item(in_data);
        if (tag.typed) owed_beats = {owed_beats, tag.want};
        else owed_beats = {owed_beats, step_res};
      end
      if (out_valid && out_ready) begin
        if (owed_beats.size() == 0) begin
          $error("result beat with nothing expected: kind %0h byte %0h error %0h",
                 out_data.kind, out_data.out_byte, out_data.error_code);
          fail_count++;
        end else begin
          want = owed_beats.pop_front();
          cmp_field("kind", 32'(want.kind), 32'(out_data.kind));
          cmp_field("out_byte", 32'(want.out_byte), 32'(out_data.out_byte));
          cmp_field("error_code", 32'(want.error_code), 32'(out_data.error_code));
          cmp_field("decoded_length", 32'(want.decoded_length),
                    32'(out_data.decoded_length));
          cmp_field("last", 32'(want.last), 32'(out_data.last));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $error("no handshake for %0d cycles, %0d beats outstanding",
               STALL_LIMIT, owed_beats.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Result side: a random stall before each beat, with quiet stretches.
  initial begin : sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = out_quiet ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 24) == 0) out_quiet = !out_quiet;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Leaves in_valid high after the beat is taken; the caller lowers it.
  task automatic drive_item(jsu_in_t it, bit typed, jsu_out_t want);
    int gap;
    row_tag_t tag;
    gap = in_quiet ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 29) == 0) in_quiet = !in_quiet;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tag.typed = typed;
    tag.want = want;
    row_tag_q = {row_tag_q, tag};
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    repeat (2) @(posedge clk);
    while (owed_beats.size() != 0) @(posedge clk);
    // An item that gives no result may still be in flight.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [23:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic void push_op(logic [1:0] op, logic [7:0] b);
    jsu_in_t it;
    it.op = op;
    it.data_byte = b;
    gen_q = {gen_q, it};
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'("0" + n);
    return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
  endfunction

  function automatic void push_hex_esc(logic [15:0] v);
    push_op(OP_TEXT, CH_BSLASH);
    push_op(OP_TEXT, CH_U);
    for (int i = 3; i >= 0; i--) push_op(OP_TEXT, hex_char(v[4*i +: 4]));
  endfunction

  function automatic logic [15:0] rand_high();
    return 16'hD800 | 16'($urandom_range(0, 16'h3FF));
  endfunction

  // One string: mostly well-formed content, now and then a fault that ends it.
  function automatic void build_string();
    int ntok;
    int k;
    bit closed;
    logic [7:0] c;
    logic [15:0] v;
    closed = 1'b0;
    push_op(OP_OPEN, rand_byte());
    ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
    for (int t = 0; t < ntok && !closed; t++) begin
      k = $urandom_range(0, 99);
      if (k < 40) begin
        do c = 8'($urandom_range(32, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
        push_op(OP_TEXT, c);
      end else if (k < 55) begin
        push_op(OP_TEXT, CH_BSLASH);
        push_op(OP_TEXT, ESC_LETTERS[$urandom_range(0, 7)]);
      end else if (k < 70) begin
        case ($urandom_range(0, 2))
          0: v = 16'($urandom_range(0, 16'h7F));
          1: v = 16'($urandom_range(16'h80, 16'h7FF));
          default: begin
            v = 16'($urandom_range(16'h800, 16'hFFFF));
            if (v[15:11] == 5'b11011) v = v ^ 16'h4000;
          end
        endcase
        push_hex_esc(v);
      end else if (k < 80) begin
        push_hex_esc(rand_high());
        push_hex_esc(16'hDC00 | 16'($urandom_range(0, 16'h3FF)));
      end else begin
        closed = 1'b1;
        case ($urandom_range(0, 9))
          0: push_op(OP_TEXT, 8'($urandom_range(0, 31)));
          1: begin
            do c = rand_byte();
            while (c inside {"\"", "\\", "/", "b", "f", "n", "r", "t", "u"});
            push_op(OP_TEXT, CH_BSLASH);
            push_op(OP_TEXT, c);
          end
          2: begin
            push_op(OP_TEXT, CH_BSLASH);
            push_op(OP_TEXT, CH_U);
            k = $urandom_range(0, 3);
            for (int j = 0; j < 4; j++) begin
              if (j == k) begin
                do c = rand_byte(); while (hex_value(c) != 5'd16);
                push_op(OP_TEXT, c);
              end else begin
                push_op(OP_TEXT, hex_char(4'($urandom_range(0, 15))));
              end
            end
          end
          3: push_hex_esc(16'hDC00 | 16'($urandom_range(0, 16'h3FF)));
          4: begin
            push_hex_esc(rand_high());
            do c = rand_byte(); while (c == CH_BSLASH);
            push_op(OP_TEXT, c);
          end
          5: begin
            push_hex_esc(rand_high());
            push_op(OP_TEXT, CH_BSLASH);
            do c = rand_byte(); while (c == CH_U);
            push_op(OP_TEXT, c);
          end
          6: begin
            push_hex_esc(rand_high());
            v = 16'($urandom_range(0, 16'hFFFF));
            if (v[15:10] == 6'b110111) v = v ^ 16'h8000;
            push_hex_esc(v);
          end
          7: begin
            // End of input cut into an escape at some depth.
            case ($urandom_range(0, 3))
              0: ;
              1: push_op(OP_TEXT, CH_BSLASH);
              2: begin
                push_op(OP_TEXT, CH_BSLASH);
                push_op(OP_TEXT, CH_U);
                repeat ($urandom_range(0, 3))
                  push_op(OP_TEXT, hex_char(4'($urandom_range(0, 15))));
              end
              default: begin
                push_hex_esc(rand_high());
                k = $urandom_range(0, 2);
                if (k > 0) push_op(OP_TEXT, CH_BSLASH);
                if (k > 1) begin
                  push_op(OP_TEXT, CH_U);
                  repeat ($urandom_range(0, 3))
                    push_op(OP_TEXT, hex_char(4'($urandom_range(0, 15))));
                end
              end
            endcase
            push_op(OP_END, rand_byte());
          end
          8: begin
            push_op(OP_SPARE, rand_byte());
            closed = 1'b0;
          end
          default: begin
            push_op(OP_OPEN, rand_byte());
            closed = 1'b0;
          end
        endcase
      end
    end
    if (!closed) begin
      k = $urandom_range(0, 19);
      if (k < 2) push_op(OP_END, rand_byte());
      else if (k > 2) push_op(OP_TEXT, CH_QUOTE);
    end
    if ($urandom_range(0, 9) == 0) push_op(2'($urandom_range(1, 3)), rand_byte());
  endfunction

  initial begin : stimulus
    jsu_in_t  it;
    jsu_out_t want;
    logic [23:0] lim;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      it.op = DIR_ROWS[i].op;
      it.data_byte = DIR_ROWS[i].data_byte;
      want.kind = DIR_ROWS[i].kind;
      want.out_byte = DIR_ROWS[i].out_byte;
      want.error_code = DIR_ROWS[i].error_code;
      want.decoded_length = DIR_ROWS[i].decoded_length;
      want.last = 1'b1;
      drive_item(it, DIR_ROWS[i].typed, want);
    end
    in_valid <= 1'b0;
    settle();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: lim = 24'd0;
        1: lim = 24'd1;
        2: lim = 24'($urandom_range(2, 40));
        3: lim = 24'hFFFFFF;
        4: lim = 24'd3;
        5: lim = 24'($urandom_range(0, 24'hFFFFFF));
        default: lim = MAX_RESET;
      endcase
      write_limit(lim);
      gen_q.delete();
      while (gen_q.size() < PHASE_ITEMS) build_string();
      foreach (gen_q[i]) begin
        // Halfway through one phase the sender holds off until all results are in.
        if (p == 3 && i == gen_q.size() / 2) begin
          in_valid <= 1'b0;
          settle();
        end
        drive_item(gen_q[i], 1'b0, '0);
      end
      in_valid <= 1'b0;
      settle();
    end

    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
